### rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared constants, record codes, state type and slot word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   localparam int MaxTasks = 16;
   localparam int SlotW    = $clog2(MaxTasks);
   localparam int CntW     = $clog2(MaxTasks + 1);

   localparam logic [1:0] RK_ACCEPT  = 2'd0;
   localparam logic [1:0] RK_FULL    = 2'd1;
   localparam logic [1:0] RK_PREEMPT = 2'd2;
   localparam logic [1:0] RK_DONE    = 2'd3;

   localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [7:0]  ident;
      logic [7:0]  prio;
      logic [31:0] arrival;
      logic [15:0] burst;
      logic [15:0] left;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_DECIDE,
      ST_RUN_RD,
      ST_RUN,
      ST_ARRIVE,
      ST_OUT1,
      ST_OUT2
   } state_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  out_task;
      logic [31:0] seg_start;
      logic [31:0] seg_end;
      logic [31:0] turnaround;
      logic [31:0] waiting;
   } rec_type;

endpackage

`default_nettype wire

### rtl/core/pts_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot table RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_slot_ram
   import pts_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [SlotW-1:0] wr_addr,
   input  wire slot_type         wr_data,
   input  wire logic [SlotW-1:0] rd_addr,
   output slot_type              rd_data
);

   slot_type mem [MaxTasks];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// Priority task scheduler
// Task table in a RAM, sequenced scan, run and retire per word.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req_     in   req_valid/ready    kind, task_id, priority_req, burst
// rsp_     out  rsp_valid/ready    record, running totals, last
// csr_     in   csr_wr_en          preempt_mode
// An arrival writes its slot in ST_ARRIVE and then delivers its record. A tick
// scans the RAM one slot a cycle, then decides and runs the chosen task, and
// delivers a record for each preempt or completion.
// Reset is synchronous; valid bits are flip-flops, the RAM needs no clearing.
// A stalled rsp_ready holds the sequencer; req_ready is high only in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top
   import pts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [15:0] req_burst,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_record_kind,
   output logic [7:0]       rsp_out_task,
   output logic [31:0]      rsp_seg_start,
   output logic [31:0]      rsp_seg_end,
   output logic [31:0]      rsp_turnaround,
   output logic [31:0]      rsp_waiting,
   output logic [15:0]      rsp_done_count,
   output logic [47:0]      rsp_total_turnaround,
   output logic [47:0]      rsp_total_waiting,
   output logic             rsp_last
);

   state_type state_ff, state_in;

   logic             mode_ff;
   logic [MaxTasks-1:0] valid_ff;
   logic             run_v_ff;
   logic [SlotW-1:0] run_s_ff;
   logic [31:0]      seg_ff, time_ff;
   logic [15:0]      fin_ff;
   logic [47:0]      sta_ff, swt_ff;

   logic [CntW-1:0]  idx_ff;
   logic             best_v_ff;
   logic [SlotW-1:0] best_s_ff;
   logic [7:0]       best_p_ff, run_p_ff;
   logic [31:0]      best_a_ff;
   logic [7:0]       id_ff, pr_ff;
   logic [15:0]      bu_ff;
   rec_type          r1_ff, r2_ff;
   logic             two_ff;
   logic [SlotW-1:0] free_s;
   logic             free_v;

   logic             wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   slot_type         wr_data, rd_data;

   pts_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      free_v = 1'b0;
      free_s = '0;
      for (int i = MaxTasks - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_v = 1'b1;
            free_s = SlotW'(i);
         end
      end
   end

   logic [SlotW-1:0] scan_s;
   logic             scan_ok, scan_better;
   logic             preempt;
   logic [15:0]      left_dec;
   logic [31:0]      t_end, ta, wt;
   logic [48:0]      sum_ta, sum_wt;
   assign scan_s   = SlotW'(idx_ff - CntW'(1));
   assign scan_ok  = valid_ff[scan_s] && !(run_v_ff && scan_s == run_s_ff);
   assign scan_better = !best_v_ff || rd_data.prio < best_p_ff ||
                        (rd_data.prio == best_p_ff && rd_data.arrival < best_a_ff);
   assign preempt  = best_v_ff && run_v_ff && mode_ff && best_p_ff < run_p_ff;
   assign left_dec = rd_data.left - 16'd1;
   assign t_end    = time_ff + 32'd1;
   assign ta       = t_end - rd_data.arrival;
   assign wt       = ta - {16'd0, rd_data.burst};
   assign sum_ta   = {1'b0, sta_ff} + {17'd0, ta};
   assign sum_wt   = {1'b0, swt_ff} + {17'd0, wt};

   always_comb begin
      rd_addr = scan_s;
      if (state_ff == ST_IDLE || state_ff == ST_RUN_RD) begin
         rd_addr = run_s_ff;
      end else if (state_ff == ST_SCAN_RD || state_ff == ST_SCAN) begin
         rd_addr = SlotW'(idx_ff);
      end else if (state_ff == ST_DECIDE) begin
         rd_addr = (run_v_ff && !preempt) ? run_s_ff : best_s_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = run_s_ff;
      wr_data = rd_data;
      wr_data.left = left_dec;
      if (state_ff == ST_ARRIVE) begin
         wr_en   = free_v;
         wr_addr = free_s;
         wr_data.ident   = id_ff;
         wr_data.prio    = pr_ff;
         wr_data.arrival = time_ff;
         wr_data.burst   = (bu_ff == 16'd0) ? 16'd1 : bu_ff;
         wr_data.left    = (bu_ff == 16'd0) ? 16'd1 : bu_ff;
      end else if (state_ff == ST_RUN) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = req_kind ? ST_ARRIVE : ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN:    if (idx_ff == CntW'(MaxTasks)) state_in = ST_DECIDE;
         ST_DECIDE:  state_in = (run_v_ff || best_v_ff) ? ST_RUN_RD : ST_IDLE;
         ST_RUN_RD:  state_in = ST_RUN;
         ST_RUN:     state_in = (two_ff || left_dec == 16'd0) ? ST_OUT1 : ST_IDLE;
         ST_ARRIVE:  state_in = ST_OUT2;
         ST_OUT1:    if (rsp_ready) state_in = two_ff ? ST_OUT2 : ST_IDLE;
         ST_OUT2:    if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b1;
         valid_ff <= '0;
         run_v_ff <= 1'b0;
         run_s_ff <= '0;
         seg_ff   <= '0;
         time_ff  <= '0;
         fin_ff   <= '0;
         sta_ff   <= '0;
         swt_ff   <= '0;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               id_ff <= req_task_id;
               pr_ff <= req_priority_req;
               bu_ff <= req_burst;
               idx_ff <= '0;
               best_v_ff <= 1'b0;
               two_ff <= 1'b0;
            end
            ST_SCAN_RD: begin
               idx_ff <= idx_ff + CntW'(1);
            end
            ST_SCAN: begin
               if (idx_ff != CntW'(MaxTasks)) begin
                  idx_ff <= idx_ff + CntW'(1);
               end
               if (scan_ok && scan_better) begin
                  best_v_ff <= 1'b1;
                  best_s_ff <= scan_s;
                  best_p_ff <= rd_data.prio;
                  best_a_ff <= rd_data.arrival;
               end
               if (run_v_ff && scan_s == run_s_ff) begin
                  run_p_ff <= rd_data.prio;
                  r1_ff.out_task <= rd_data.ident;
               end
            end
            ST_DECIDE: begin
               r1_ff.record_kind <= RK_PREEMPT;
               r1_ff.seg_start   <= seg_ff;
               r1_ff.seg_end     <= time_ff;
               r1_ff.turnaround  <= '0;
               r1_ff.waiting     <= '0;
               if (!run_v_ff && best_v_ff) begin
                  run_v_ff <= 1'b1;
                  run_s_ff <= best_s_ff;
                  seg_ff   <= time_ff;
               end else if (preempt) begin
                  two_ff   <= 1'b1;
                  run_s_ff <= best_s_ff;
                  seg_ff   <= time_ff;
               end
               if (!(run_v_ff || best_v_ff)) begin
                  time_ff <= t_end;
               end
            end
            ST_RUN: begin
               time_ff <= t_end;
               r2_ff.record_kind <= RK_DONE;
               r2_ff.out_task    <= rd_data.ident;
               r2_ff.seg_start   <= seg_ff;
               r2_ff.seg_end     <= t_end;
               r2_ff.turnaround  <= ta;
               r2_ff.waiting     <= wt;
               if (left_dec == 16'd0) begin
                  valid_ff[run_s_ff] <= 1'b0;
                  run_v_ff <= 1'b0;
                  sta_ff <= sum_ta[48] ? Max48 : sum_ta[47:0];
                  swt_ff <= sum_wt[48] ? Max48 : sum_wt[47:0];
                  if (fin_ff != 16'hFFFF) begin
                     fin_ff <= fin_ff + 16'd1;
                  end
                  if (!two_ff) begin
                     r1_ff.record_kind <= RK_DONE;
                     r1_ff.out_task    <= rd_data.ident;
                     r1_ff.seg_start   <= seg_ff;
                     r1_ff.seg_end     <= t_end;
                     r1_ff.turnaround  <= ta;
                     r1_ff.waiting     <= wt;
                  end
               end else begin
                  two_ff <= 1'b0;
               end
            end
            ST_ARRIVE: begin
               r2_ff.record_kind <= free_v ? RK_ACCEPT : RK_FULL;
               r2_ff.out_task    <= id_ff;
               r2_ff.seg_start   <= '0;
               r2_ff.seg_end     <= '0;
               r2_ff.turnaround  <= '0;
               r2_ff.waiting     <= '0;
               if (free_v) begin
                  valid_ff[free_s] <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ST_RUN with a preempt but no completion: drop the second record
   logic keep2;
   assign keep2 = two_ff;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT1) || (state_ff == ST_OUT2);
      rsp_last  = (state_ff == ST_OUT2) || !keep2;
      {rsp_record_kind, rsp_out_task, rsp_seg_start, rsp_seg_end,
       rsp_turnaround, rsp_waiting} = (state_ff == ST_OUT2) ? r2_ff : r1_ff;
      rsp_done_count       = fin_ff;
      rsp_total_turnaround = sta_ff;
      rsp_total_waiting    = swt_ff;
   end

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Sends arrival and tick words, predicts every record from a local copy of
// the task table, and checks each record field by field under random stalls.
// ----------------------------------------------------------------------------

module testbench;
   import pts_pkg::*;

   localparam int WatchLimit = 4000;
   localparam int DrainCycles = 60;
   localparam logic KindTick = 1'b0;
   localparam logic KindArrive = 1'b1;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  task_id;
      logic [31:0] seg_start;
      logic [31:0] seg_end;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic [15:0] done_count;
      logic [47:0] total_ta;
      logic [47:0] total_wait;
      logic        last;
   } sched_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_task_id = 8'd0;
   logic [7:0]  req_priority_req = 8'd0;
   logic [15:0] req_burst = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [7:0]  rsp_out_task;
   logic [31:0] rsp_seg_start;
   logic [31:0] rsp_seg_end;
   logic [31:0] rsp_turnaround;
   logic [31:0] rsp_waiting;
   logic [15:0] rsp_done_count;
   logic [47:0] rsp_total_turnaround;
   logic [47:0] rsp_total_waiting;
   logic        rsp_last;

   // scheduler image
   logic        mode;
   logic        tab_valid [MaxTasks];
   logic [7:0]  tab_ident [MaxTasks];
   logic [7:0]  tab_prio [MaxTasks];
   logic [31:0] tab_arrival [MaxTasks];
   logic [15:0] tab_burst [MaxTasks];
   logic [15:0] tab_left [MaxTasks];
   logic        run_valid;
   int          run_slot;
   logic [31:0] seg_begin;
   logic [31:0] now;
   logic [15:0] finished;
   logic [47:0] sum_ta;
   logic [47:0] sum_wait;

   sched_rec_type pending_recs[$];
   int          send_idle = 0;
   int          rsp_idle = 0;
   int          quiet_cycles = 0;
   bit          failed = 1'b0;

   always #2 clock = ~clock;

   priority_task_scheduler_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_task_id(req_task_id), .req_priority_req(req_priority_req),
      .req_burst(req_burst),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_record_kind(rsp_record_kind), .rsp_out_task(rsp_out_task),
      .rsp_seg_start(rsp_seg_start), .rsp_seg_end(rsp_seg_end),
      .rsp_turnaround(rsp_turnaround), .rsp_waiting(rsp_waiting),
      .rsp_done_count(rsp_done_count),
      .rsp_total_turnaround(rsp_total_turnaround),
      .rsp_total_waiting(rsp_total_waiting), .rsp_last(rsp_last)
   );

   function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? Max48 : s[47:0];
   endfunction

   function automatic sched_rec_type make_rec(logic [1:0] k, logic [7:0] id,
      logic [31:0] s, logic [31:0] e, logic [31:0] ta, logic [31:0] w);
      sched_rec_type r;
      r.kind = k; r.task_id = id; r.seg_start = s; r.seg_end = e;
      r.turnaround = ta; r.waiting = w; r.last = 1'b0;
      return r;
   endfunction

   function automatic int best_ready();
      int best;
      best = -1;
      for (int i = 0; i < MaxTasks; i++) begin
         if (!tab_valid[i] || (run_valid && i == run_slot)) continue;
         if (best < 0 || tab_prio[i] < tab_prio[best] ||
             (tab_prio[i] == tab_prio[best] && tab_arrival[i] < tab_arrival[best]))
            best = i;
      end
      return best;
   endfunction

   task automatic schedule_word(logic k, logic [7:0] id, logic [7:0] pr,
                                logic [15:0] b);
      sched_rec_type recs[$];
      int       free;
      int       best;
      int       r;
      logic [31:0] fin;
      logic [31:0] ta;
      logic [31:0] w;
      if (k == KindArrive) begin
         free = -1;
         for (int i = MaxTasks - 1; i >= 0; i--) if (!tab_valid[i]) free = i;
         if (free >= 0) begin
            tab_valid[free] = 1'b1;
            tab_ident[free] = id;
            tab_prio[free] = pr;
            tab_arrival[free] = now;
            tab_burst[free] = (b == 16'd0) ? 16'd1 : b;
            tab_left[free] = tab_burst[free];
            recs = {recs, make_rec(RK_ACCEPT, id, 0, 0, 0, 0)};
         end else begin
            recs = {recs, make_rec(RK_FULL, id, 0, 0, 0, 0)};
         end
      end else begin
         best = best_ready();
         if (best >= 0) begin
            if (!run_valid) begin
               run_valid = 1'b1;
               run_slot = best;
               seg_begin = now;
            end else if (mode && tab_prio[best] < tab_prio[run_slot]) begin
               recs = {recs, make_rec(RK_PREEMPT, tab_ident[run_slot],
                                      seg_begin, now, 0, 0)};
               run_slot = best;
               seg_begin = now;
            end
         end
         if (run_valid) begin
            r = run_slot;
            tab_left[r] = tab_left[r] - 16'd1;
            if (tab_left[r] == 16'd0) begin
               fin = now + 32'd1;
               ta = fin - tab_arrival[r];
               w = ta - {16'd0, tab_burst[r]};
               sum_ta = sat_add(sum_ta, ta);
               sum_wait = sat_add(sum_wait, w);
               if (finished != 16'hFFFF) finished++;
               tab_valid[r] = 1'b0;
               run_valid = 1'b0;
               recs = {recs, make_rec(RK_DONE, tab_ident[r], seg_begin, fin, ta, w)};
            end
         end
         now++;
      end
      foreach (recs[i]) begin
         recs[i].done_count = finished;
         recs[i].total_ta = sum_ta;
         recs[i].total_wait = sum_wait;
         recs[i].last = (i == recs.size() - 1);
         pending_recs = {pending_recs, recs[i]};
      end
   endtask

   task automatic send_word(logic k, logic [7:0] id, logic [7:0] pr, logic [15:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_task_id <= id;
      req_priority_req <= pr;
      req_burst <= b;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      schedule_word(k, id, pr, b);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending_recs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode = m;
   endtask

   task automatic test_directed();
      write_mode(1'b1);
      send_word(KindTick, 8'd0, 8'd0, 16'd1);
      send_word(KindArrive, 8'd255, 8'd255, 16'd0);
      send_word(KindArrive, 8'd0, 8'd255, 16'hFFFF);
      send_word(KindArrive, 8'd1, 8'd0, 16'd2);
      for (int i = 0; i < 13; i++)
         send_word(KindArrive, 8'(i + 2), 8'(i % 3), 16'(1 + i % 2));
      send_word(KindArrive, 8'd99, 8'd1, 16'd1);
      for (int i = 0; i < 5; i++) send_word(KindTick, 8'd0, 8'd0, 16'd1);
   endtask

   task automatic test_random(int words, logic m);
      logic [7:0]  pr;
      logic [15:0] b;
      int          pick;
      write_mode(m);
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(99) < 35) begin
            pick = $urandom_range(99);
            pr = ($urandom_range(1)) ? 8'($urandom_range(7)) : 8'($urandom);
            if (pick < 1) begin
               b = 16'($urandom);
               pr = 8'd255;
            end else if (pick < 6) b = 16'd0;
            else b = 16'($urandom_range(1, 6));
            send_word(KindArrive, 8'($urandom), pr, b);
         end else begin
            send_word(KindTick, 8'($urandom), 8'($urandom), 16'($urandom));
         end
      end
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_idle);

   function automatic void check_field(string name, logic [47:0] expd,
                                       logic [47:0] act);
      if (expd !== act) begin
         $display("%0t %s expected %0h actual %0h", $time, name, expd, act);
         failed = 1'b1;
      end
   endfunction

   always @(negedge clock) begin
      sched_rec_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_recs.size() == 0) begin
            $display("%0t unexpected record expected none actual kind %0d",
                     $time, rsp_record_kind);
            failed = 1'b1;
         end else begin
            e = pending_recs.pop_front();
            check_field("record_kind", 48'(e.kind), 48'(rsp_record_kind));
            check_field("out_task", 48'(e.task_id), 48'(rsp_out_task));
            check_field("seg_start", 48'(e.seg_start), 48'(rsp_seg_start));
            check_field("seg_end", 48'(e.seg_end), 48'(rsp_seg_end));
            check_field("turnaround", 48'(e.turnaround), 48'(rsp_turnaround));
            check_field("waiting", 48'(e.waiting), 48'(rsp_waiting));
            check_field("done_count", 48'(e.done_count), 48'(rsp_done_count));
            check_field("total_turnaround", e.total_ta, rsp_total_turnaround);
            check_field("total_waiting", e.total_wait, rsp_total_waiting);
            check_field("last", 48'(e.last), 48'(rsp_last));
         end
      end
      if (reset || (rsp_valid && rsp_ready) || (req_valid && req_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      mode = 1'b1;
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      run_valid = 1'b0; run_slot = 0; seg_begin = 0; now = 0;
      finished = 0; sum_ta = 0; sum_wait = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle = 17; rsp_idle = 47;
      test_random(560, 1'b0);
      send_idle = 47; rsp_idle = 17;
      test_random(560, 1'b1);
      send_idle = 0; rsp_idle = 0;
      test_random(560, 1'b0);
      wait_idle();
      if (!failed && pending_recs.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
